// File: design/cmn_pkg.sv
// Shared constants and controller/datapath interface types for the meeting node finder.
package cmn_pkg;

  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int DIST_W    = IDX_W + 1;
  localparam int FIELD_W   = 10;
  localparam int EDGE_W    = FIELD_W + 1;

  localparam logic [DIST_W-1:0] UNREACHED = '1;
  localparam logic [CNT_W-1:0]  NODE_LIMIT = CNT_W'(MAX_NODES);

  localparam logic SEL_FIRST  = 1'b0;
  localparam logic SEL_SECOND = 1'b1;

  typedef struct packed {
    logic load;        // store the accepted beat
    logic walk_start;  // seed a walk at its source
    logic walk_sel;    // which distance table the walk uses
    logic edge_rd;     // fetch edge of current node
    logic dist_rd;     // fetch distance of the edge target
    logic step;        // move to the edge target
    logic scan_init;
    logic scan;
    logic publish;     // load result register, restart the graph
  } cmn_cmd_t;

  typedef struct packed {
    logic start_ok;    // source is inside the loaded graph
    logic next_ok;     // fetched edge is valid and in range
    logic next_free;   // edge target not yet reached
    logic scan_done;
    logic out_free;    // result register can take a new beat
  } cmn_sts_t;

endpackage

// File: design/cmn_ctrl.sv
// Sequencer: load, two pointer walks, minimum scan and result hand-off.
module cmn_ctrl import cmn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     last_node_i,
  output logic     in_stall_o,
  input  cmn_sts_t sts_i,
  output cmn_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_WALK_START,
    ST_WALK_EDGE,
    ST_WALK_DIST,
    ST_WALK_STEP,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_REPORT
  } state_e;

  state_e state_q, state_d;
  logic   sel_q, sel_d;

  assign in_stall_o = (state_q != ST_LOAD);

  always_comb begin
    cmd_o          = '0;
    cmd_o.walk_sel = sel_q;
    state_d        = state_q;
    sel_d          = sel_q;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_node_i) begin
            sel_d   = SEL_FIRST;
            state_d = ST_WALK_START;
          end
        end
      end
      ST_WALK_START: begin
        cmd_o.walk_start = 1'b1;
        if (sts_i.start_ok) begin
          state_d = ST_WALK_EDGE;
        end else if (sel_q == SEL_FIRST) begin
          sel_d = SEL_SECOND;
        end else begin
          state_d = ST_SCAN_INIT;
        end
      end
      ST_WALK_EDGE: begin
        cmd_o.edge_rd = 1'b1;
        state_d       = ST_WALK_DIST;
      end
      ST_WALK_DIST: begin
        cmd_o.dist_rd = 1'b1;
        if (sts_i.next_ok) begin
          state_d = ST_WALK_STEP;
        end else if (sel_q == SEL_FIRST) begin
          sel_d   = SEL_SECOND;
          state_d = ST_WALK_START;
        end else begin
          state_d = ST_SCAN_INIT;
        end
      end
      ST_WALK_STEP: begin
        if (sts_i.next_free) begin
          cmd_o.step = 1'b1;
          state_d    = ST_WALK_EDGE;
        end else if (sel_q == SEL_FIRST) begin
          sel_d   = SEL_SECOND;
          state_d = ST_WALK_START;
        end else begin
          state_d = ST_SCAN_INIT;
        end
      end
      ST_SCAN_INIT: begin
        cmd_o.scan_init = 1'b1;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      sel_q   <= SEL_FIRST;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// File: design/cmn_dpath.sv
// Datapath: edge and distance memories, walk registers, scan and result register.
module cmn_dpath import cmn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmn_cmd_t           cmd_i,
  output cmn_sts_t           sts_o,
  input  logic [FIELD_W-1:0] edge_target_i,
  input  logic               has_edge_i,
  input  logic               last_node_i,
  input  logic [FIELD_W-1:0] source_a_i,
  input  logic [FIELD_W-1:0] source_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [FIELD_W-1:0] meeting_node_o
);

  logic [EDGE_W-1:0] edge_mem [MAX_NODES];
  logic [DIST_W-1:0] dist_a_mem [MAX_NODES];
  logic [DIST_W-1:0] dist_b_mem [MAX_NODES];

  logic [CNT_W-1:0]   cnt_q;
  logic [FIELD_W-1:0] src_a_q, src_b_q;
  logic [IDX_W-1:0]   node_q;
  logic [DIST_W-1:0]  hops_q;
  logic [EDGE_W-1:0]  edge_rd_q;
  logic [DIST_W-1:0]  da_q, db_q;
  logic [CNT_W-1:0]   scan_q;
  logic               scan_vld_q;
  logic [IDX_W-1:0]   scan_idx_q;
  logic [DIST_W-1:0]  best_dist_q;
  logic [IDX_W-1:0]   best_node_q;
  logic               out_valid_q, found_q;
  logic [FIELD_W-1:0] meeting_q;

  logic               room;
  logic [FIELD_W-1:0] src_sel;
  logic [IDX_W-1:0]   next_idx;
  logic               scan_issue;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [DIST_W-1:0]  wr_data;
  logic               wr_a, wr_b, wr_any;
  logic [DIST_W-1:0]  dist_sel;
  logic [DIST_W-1:0]  dist_max;
  logic               better;

  assign room       = (cnt_q < NODE_LIMIT);
  assign src_sel    = (cmd_i.walk_sel == SEL_SECOND) ? src_b_q : src_a_q;
  assign next_idx   = IDX_W'(edge_rd_q[FIELD_W-1:0]);
  assign scan_issue = cmd_i.scan && (scan_q < cnt_q);
  assign dist_sel   = (cmd_i.walk_sel == SEL_SECOND) ? db_q : da_q;

  assign sts_o.start_ok  = (32'(src_sel) < 32'(cnt_q));
  assign sts_o.next_ok   = edge_rd_q[FIELD_W] &&
                           (32'(edge_rd_q[FIELD_W-1:0]) < 32'(cnt_q));
  assign sts_o.next_free = (dist_sel == UNREACHED);
  assign sts_o.scan_done = (scan_q == cnt_q) && !scan_vld_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // distance memory port steering
  always_comb begin
    rd_addr = cmd_i.dist_rd ? next_idx : scan_q[IDX_W-1:0];
    wr_addr = cnt_q[IDX_W-1:0];
    wr_data = UNREACHED;
    wr_any  = 1'b0;
    if (cmd_i.load) begin
      wr_any = room;
    end else if (cmd_i.walk_start) begin
      wr_addr = IDX_W'(src_sel);
      wr_data = '0;
      wr_any  = sts_o.start_ok;
    end else if (cmd_i.step) begin
      wr_addr = next_idx;
      wr_data = hops_q + DIST_W'(1);
      wr_any  = 1'b1;
    end
    wr_a = wr_any && (cmd_i.load || cmd_i.walk_sel == SEL_FIRST);
    wr_b = wr_any && (cmd_i.load || cmd_i.walk_sel == SEL_SECOND);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      edge_mem[cnt_q[IDX_W-1:0]] <= {has_edge_i, edge_target_i};
    end
    if (cmd_i.edge_rd) begin
      edge_rd_q <= edge_mem[node_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      dist_a_mem[wr_addr] <= wr_data;
    end
    da_q <= dist_a_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      dist_b_mem[wr_addr] <= wr_data;
    end
    db_q <= dist_b_mem[rd_addr];
  end

  // walk and source registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && last_node_i) begin
      src_a_q <= source_a_i;
      src_b_q <= source_b_i;
    end
    if (cmd_i.walk_start) begin
      node_q <= IDX_W'(src_sel);
      hops_q <= '0;
    end else if (cmd_i.step) begin
      node_q <= next_idx;
      hops_q <= hops_q + DIST_W'(1);
    end
    if (scan_issue) begin
      scan_idx_q <= scan_q[IDX_W-1:0];
    end
  end

  assign dist_max = (da_q > db_q) ? da_q : db_q;
  assign better   = scan_vld_q && (da_q != UNREACHED) && (db_q != UNREACHED) &&
                    (dist_max < best_dist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      scan_q      <= '0;
      scan_vld_q  <= 1'b0;
      best_dist_q <= UNREACHED;
      best_node_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && room) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.publish) begin
        cnt_q <= '0;
      end
      if (cmd_i.scan_init) begin
        scan_q      <= '0;
        scan_vld_q  <= 1'b0;
        best_dist_q <= UNREACHED;
        best_node_q <= '0;
      end else begin
        if (scan_issue) begin
          scan_q <= scan_q + CNT_W'(1);
        end
        scan_vld_q <= scan_issue;
        // strict compare keeps the lowest index on a tie
        if (better) begin
          best_dist_q <= dist_max;
          best_node_q <= scan_idx_q;
        end
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      found_q   <= (best_dist_q != UNREACHED);
      meeting_q <= (best_dist_q != UNREACHED) ? FIELD_W'(best_node_q) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign meeting_node_o = meeting_q;

endmodule

// File: design/closest_meeting_node_finder.sv
// One node beat is accepted per cycle while loading; the last beat starts the search.
// Search: each walk is seeded, then takes an edge read, a distance read and an update per hop
// until it finds its end; a source outside the graph ends its walk at the seed step.
// Then the nodes are scanned and the result is published; publishing waits while the previous result is stalled.
// One graph is handled at a time; loading of the next graph starts once the result is queued.
// Reset (rst_ni low, async) empties the graph and the result register; tables hold no reset.
module closest_meeting_node_finder import cmn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FIELD_W-1:0] edge_target_i,
  input  logic               has_edge_i,
  input  logic               last_node_i,
  input  logic [FIELD_W-1:0] source_a_i,
  input  logic [FIELD_W-1:0] source_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [FIELD_W-1:0] meeting_node_o
);

  cmn_cmd_t cmd;
  cmn_sts_t sts;

  cmn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_node_i (last_node_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cmn_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .edge_target_i  (edge_target_i),
    .has_edge_i     (has_edge_i),
    .last_node_i    (last_node_i),
    .source_a_i     (source_a_i),
    .source_b_i     (source_b_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .meeting_node_o (meeting_node_o)
  );

endmodule
